### hw/rtl/assert_macros.svh
// Assertion macros for the holding register access RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk, muted while rst_n is low.
`define HRA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define HRA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hw/rtl/hra_pkg.sv
// Package for the holding register access block: sizes, codes and shared types.
`timescale 1ns / 1ps

package hra_pkg;

  localparam int TABLE_DEPTH = 128;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  localparam int ADDR_W   = 16;
  localparam int COUNT_W  = 16;
  localparam int OFFSET_W = 7;
  localparam int WORD_W   = 16;
  localparam int SIZE_W   = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // in_tdata: start_address, reg_count, word_offset, write_data, zero fill
  localparam int IN_DATA_BITS = ADDR_W + COUNT_W + OFFSET_W + WORD_W;
  localparam int IN_TDATA_W   = ((IN_DATA_BITS + 7) / 8) * 8;

  localparam logic [CFG_IDX_W-1:0] CFG_HOLDING_SIZE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_BASE   = CFG_IDX_W'(1);

  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOREG  = 2'd1,
    ST_BEYOND = 2'd2
  } status_t;

  // One word access handed from the check logic to the store.
  typedef struct packed {
    logic             rd_en;
    logic             wr_en;
    logic [IDX_W-1:0] idx;
  } access_t;

endpackage

### hw/rtl/holding_register_access.sv
// Top level of the holding register access block: ports, stage registers, config.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Channel  Ports            Beat fields (low bit up)
// -------  ---------------  ----------------------------------------------------
// in       in_t*            tuser: action | tdata: start_address, reg_count,
//                           word_offset, write_data, zero fill to 56 bits
// out      out_t*           tuser: status | tdata: read_data
// cfg      cfg_*            cfg_index: 0 holding_size, 1 table_base | cfg_data
//
// One beat per cycle sustained while out is not stalled; a taken beat enters the input
// register, moves through check plus memory access into the result register and is
// presented on out from there.
// Reset clears control state, config and the valid bit of every memory entry at
// once; no clearing pass, so in_tready is up the cycle after reset.
// A stalled out beat holds the result register and the input register; in_tready
// follows out_tready combinationally through that two-stage chain.
// cfg_ready is always high; writes take effect on the next beat checked.

module holding_register_access
  import hra_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // action
  input  logic [0:0]            in_tuser,
  // start_address, reg_count, word_offset, write_data
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // status
  output logic [1:0]            out_tuser,
  // read_data
  output logic [WORD_W-1:0]     out_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CNT_LO = ADDR_W;
  localparam int OFF_LO = ADDR_W + COUNT_W;
  localparam int WD_LO  = ADDR_W + COUNT_W + OFFSET_W;

  // config registers
  logic [SIZE_W-1:0] holding_size_r;
  logic [ADDR_W-1:0] table_base_r;

  // input stage
  logic                s1_valid_r;
  logic                s1_action_r;
  logic [ADDR_W-1:0]   s1_start_r;
  logic [COUNT_W-1:0]  s1_count_r;
  logic [OFFSET_W-1:0] s1_offset_r;
  logic [WORD_W-1:0]   s1_wdata_r;

  // result stage
  logic    out_valid_r;
  status_t out_status_r;
  logic    out_rd_r;

  status_t           chk_status;
  access_t           chk_acc;
  logic [WORD_W-1:0] store_rdata;
  logic              out_free;
  logic              advance;
  logic              in_take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      holding_size_r <= '0;
      table_base_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_HOLDING_SIZE: holding_size_r <= cfg_data[SIZE_W-1:0];
        CFG_TABLE_BASE:   table_base_r   <= cfg_data[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_free  = !out_valid_r || out_tready;
  assign advance   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_take   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_action_r <= in_tuser[0];
      s1_start_r  <= in_tdata[CNT_LO-1:0];
      s1_count_r  <= in_tdata[OFF_LO-1:CNT_LO];
      s1_offset_r <= in_tdata[WD_LO-1:OFF_LO];
      s1_wdata_r  <= in_tdata[WD_LO+WORD_W-1:WD_LO];
    end
  end

  hra_check u_check (
    .holding_size  (holding_size_r),
    .table_base    (table_base_r),
    .action        (s1_action_r),
    .start_address (s1_start_r),
    .reg_count     (s1_count_r),
    .word_offset   (s1_offset_r),
    .status        (chk_status),
    .acc           (chk_acc)
  );

  hra_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .acc     (chk_acc),
    .wdata   (s1_wdata_r),
    .rdata   (store_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_status_r <= chk_status;
      out_rd_r     <= chk_acc.rd_en;
    end
  end

  // read data only on a read that passed every check
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = out_rd_r ? store_rdata : '0;

  `HRA_ASSERT(a_fail_no_data, out_valid_r && (out_status_r != ST_OK) |-> out_tdata == '0, "failed access returned data")
  `HRA_ASSERT(a_advance_lands, advance |=> out_valid_r, "checked beat did not reach the result register")
  `HRA_ASSERT(a_stall_blocks_in, s1_valid_r && !out_free |-> !in_tready, "input taken while the pipe is stalled")

endmodule

### hw/rtl/hra_check.sv
// Range check and index calculation for one word access.
`timescale 1ns / 1ps

module hra_check
  import hra_pkg::*;
(
  input  logic [SIZE_W-1:0]   holding_size,
  input  logic [ADDR_W-1:0]   table_base,
  input  logic                action,
  input  logic [ADDR_W-1:0]   start_address,
  input  logic [COUNT_W-1:0]  reg_count,
  input  logic [OFFSET_W-1:0] word_offset,
  output status_t             status,
  output access_t             acc
);

  logic [ADDR_W-1:0] addr;
  logic [ADDR_W:0]   span;
  logic [ADDR_W-1:0] idx_full;
  logic              no_reg;
  logic              past_count;
  logic              past_depth;

  // one-based to zero-based, wraps on address zero
  assign addr = start_address - ADDR_W'(1);
  assign span = {1'b0, addr} + (ADDR_W + 1)'(reg_count);
  assign no_reg = span > (ADDR_W + 1)'(holding_size);
  assign past_count = COUNT_W'(word_offset) >= reg_count;
  assign idx_full = addr - table_base + ADDR_W'(word_offset);
  assign past_depth = {1'b0, idx_full} >= (ADDR_W + 1)'(TABLE_DEPTH);

  always_comb begin
    status    = ST_OK;
    acc.rd_en = 1'b0;
    acc.wr_en = 1'b0;
    acc.idx   = idx_full[IDX_W-1:0];
    if (no_reg) begin
      status = ST_NOREG;
    end else if (past_count || past_depth) begin
      status = ST_BEYOND;
    end else if (action == ACT_WRITE) begin
      acc.wr_en = 1'b1;
    end else begin
      acc.rd_en = 1'b1;
    end
  end

endmodule

### hw/rtl/hra_store.sv
// Holding register memory with per-entry valid bits and registered read.
`timescale 1ns / 1ps

module hra_store
  import hra_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  access_t           acc,
  input  logic [WORD_W-1:0] wdata,
  output logic [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0]      mem_r [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] vld_r;
  logic [WORD_W-1:0]      q_r;
  logic                   hit_r;

  always_ff @(posedge clk) begin
    if (advance && acc.wr_en) begin
      mem_r[acc.idx] <= wdata;
    end
    if (advance && acc.rd_en) begin
      q_r <= mem_r[acc.idx];
    end
  end

  // never-written entries read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      hit_r <= 1'b0;
    end else if (advance) begin
      if (acc.wr_en) begin
        vld_r[acc.idx] <= 1'b1;
      end
      if (acc.rd_en) begin
        hit_r <= vld_r[acc.idx];
      end
    end
  end

  assign rdata = hit_r ? q_r : '0;

endmodule
